>>> hdl/bmrg_pkg.sv
package bmrg_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int COEF_BITS       = 16;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int LEVEL_FRAC_BITS = 8;
  localparam int LEVEL_BITS      = SAMPLE_BITS + LEVEL_FRAC_BITS;
  localparam int THRESH_BITS     = 12;
  localparam int CFG_ADDR_BITS   = 5;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEF_B0        = 3'd0,
    REG_COEF_B1        = 3'd1,
    REG_COEF_A0        = 3'd2,
    REG_CRITICAL_LEVEL = 3'd3,
    REG_WARNING_LEVEL  = 3'd4,
    REG_BATTERY_SUPPLY = 3'd5,
    REG_START_ENABLED  = 3'd6
  } bmrg_reg_t;

  localparam logic [COEF_BITS-1:0]   COEF_B0_RST        = 16'sd8192;
  localparam logic [COEF_BITS-1:0]   COEF_B1_RST        = 16'sd8192;
  localparam logic [COEF_BITS-1:0]   COEF_A0_RST        = -16'sd8192;
  localparam logic [THRESH_BITS-1:0] CRITICAL_LEVEL_RST = 12'd2800;
  localparam logic [THRESH_BITS-1:0] WARNING_LEVEL_RST  = 12'd3000;
  localparam logic                   BATTERY_SUPPLY_RST = 1'b1;
  localparam logic                   START_ENABLED_RST  = 1'b1;

  typedef struct packed {
    logic [COEF_BITS-1:0] b0;
    logic [COEF_BITS-1:0] b1;
    logic [COEF_BITS-1:0] a0;
  } bmrg_coef_t;

  typedef struct packed {
    logic [11:0] supply_code;
    logic        button_press;
  } bmrg_in_t;

  typedef struct packed {
    logic [19:0] filtered_level;
    logic        below_warning;
    logic        below_critical;
    logic        drive_enable;
    logic        enable_changed;
  } bmrg_out_t;

endpackage

>>> hdl/bmrg_iir.sv
module bmrg_iir import bmrg_pkg::*; (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] prev_sample,
  input  logic [LEVEL_BITS-1:0]  level_prev,
  input  bmrg_coef_t             coef,
  input  logic                   first,
  output logic [LEVEL_BITS-1:0]  level
);

  localparam int PROD_X_W = COEF_BITS + SAMPLE_BITS + 1;
  localparam int PROD_Y_W = COEF_BITS + LEVEL_BITS + 1;
  localparam int ACC_W    = COEF_BITS + LEVEL_BITS + 3;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PROD_X_W-1:0] prod_b0;
  logic signed [PROD_X_W-1:0] prod_b1;
  logic signed [PROD_Y_W-1:0] prod_a0;
  logic [ACC_W-1:0]           ext_b0;
  logic [ACC_W-1:0]           ext_b1;
  logic [ACC_W-1:0]           ext_a0;
  logic [ACC_W-1:0]           acc;
  logic                       acc_neg;
  logic                       acc_over;

  // samples carry no fraction bits yet; scale after the multiply
  assign prod_b0 = $signed({{(PROD_X_W-COEF_BITS){coef.b0[COEF_BITS-1]}}, coef.b0})
                 * $signed({{(PROD_X_W-SAMPLE_BITS){1'b0}}, sample});
  assign prod_b1 = $signed({{(PROD_X_W-COEF_BITS){coef.b1[COEF_BITS-1]}}, coef.b1})
                 * $signed({{(PROD_X_W-SAMPLE_BITS){1'b0}}, prev_sample});
  assign prod_a0 = $signed({{(PROD_Y_W-COEF_BITS){coef.a0[COEF_BITS-1]}}, coef.a0})
                 * $signed({{(PROD_Y_W-LEVEL_BITS){1'b0}}, level_prev});

  assign ext_b0 = {{(ACC_W-PROD_X_W){prod_b0[PROD_X_W-1]}}, prod_b0} << LEVEL_FRAC_BITS;
  assign ext_b1 = {{(ACC_W-PROD_X_W){prod_b1[PROD_X_W-1]}}, prod_b1} << LEVEL_FRAC_BITS;
  assign ext_a0 = {{(ACC_W-PROD_Y_W){prod_a0[PROD_Y_W-1]}}, prod_a0};

  assign acc      = ext_b0 + ext_b1 - ext_a0 + ROUND_HALF;
  assign acc_neg  = acc[ACC_W-1];
  assign acc_over = |acc[ACC_W-1:COEF_FRAC_BITS+LEVEL_BITS];

  always_comb begin
    if (first) begin
      level = {sample, {LEVEL_FRAC_BITS{1'b0}}};
    end else if (acc_neg) begin
      level = '0;
    end else if (acc_over) begin
      level = '1;
    end else begin
      level = acc[COEF_FRAC_BITS +: LEVEL_BITS];
    end
  end

endmodule

>>> hdl/battery_monitor_regulation_gate_core.sv
// Supply monitor with regulation gate. Each request carries one supply ADC code and a
// button-press flag and yields one result: the first-order IIR filtered level (8 fraction
// bits, rounded half up, saturated), below-warning and below-critical flags, the drive
// enable and its change flag. The first request after reset loads the filter and forces the
// change flag. A request passes the input register and then the result register; a new
// request is taken every cycle unless the result register is full and stalled; the filter
// feedback (three coefficient products, sum, round, saturate and compare) is combinational.
// Coefficients and thresholds sit on the cfg_ APB port, registers at 4*index.
module battery_monitor_regulation_gate_core import bmrg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  bmrg_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output bmrg_out_t                out_data,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // configuration
  bmrg_coef_t             coef_r;
  logic [THRESH_BITS-1:0] critical_level_r;
  logic [THRESH_BITS-1:0] warning_level_r;
  logic                   battery_supply_r;
  logic                   start_enabled_r;
  bmrg_reg_t              cfg_index;
  logic                   cfg_write;

  // pipeline
  logic      in_valid_r;
  bmrg_in_t  in_data_r;
  logic      out_valid_r;
  bmrg_out_t out_data_r;
  bmrg_out_t out_data_nxt;
  logic      fire;
  logic      in_take;

  // filter state
  logic [SAMPLE_BITS-1:0] prev_sample_r;
  logic [LEVEL_BITS-1:0]  filter_out_r;
  logic                   button_enable_r;
  logic                   voltage_ok_r;
  logic                   last_reported_r;
  logic                   primed_r;
  logic [SAMPLE_BITS-1:0] prev_sample_nxt;
  logic [LEVEL_BITS-1:0]  filter_out_nxt;
  logic                   button_enable_nxt;
  logic                   voltage_ok_nxt;
  logic                   below_c_nxt;
  logic                   below_w_nxt;
  logic                   drive_nxt;
  logic                   first;

  assign cfg_pready = 1'b1;
  assign cfg_index  = bmrg_reg_t'(cfg_paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0        <= COEF_B0_RST;
      coef_r.b1        <= COEF_B1_RST;
      coef_r.a0        <= COEF_A0_RST;
      critical_level_r <= CRITICAL_LEVEL_RST;
      warning_level_r  <= WARNING_LEVEL_RST;
      battery_supply_r <= BATTERY_SUPPLY_RST;
      start_enabled_r  <= START_ENABLED_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_B0:        coef_r.b0        <= cfg_pwdata[COEF_BITS-1:0];
        REG_COEF_B1:        coef_r.b1        <= cfg_pwdata[COEF_BITS-1:0];
        REG_COEF_A0:        coef_r.a0        <= cfg_pwdata[COEF_BITS-1:0];
        REG_CRITICAL_LEVEL: critical_level_r <= cfg_pwdata[THRESH_BITS-1:0];
        REG_WARNING_LEVEL:  warning_level_r  <= cfg_pwdata[THRESH_BITS-1:0];
        REG_BATTERY_SUPPLY: battery_supply_r <= cfg_pwdata[0];
        REG_START_ENABLED:  start_enabled_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_COEF_B0:
        cfg_prdata = {{(CFG_DATA_BITS-COEF_BITS){coef_r.b0[COEF_BITS-1]}}, coef_r.b0};
      REG_COEF_B1:
        cfg_prdata = {{(CFG_DATA_BITS-COEF_BITS){coef_r.b1[COEF_BITS-1]}}, coef_r.b1};
      REG_COEF_A0:
        cfg_prdata = {{(CFG_DATA_BITS-COEF_BITS){coef_r.a0[COEF_BITS-1]}}, coef_r.a0};
      REG_CRITICAL_LEVEL: cfg_prdata = CFG_DATA_BITS'(critical_level_r);
      REG_WARNING_LEVEL:  cfg_prdata = CFG_DATA_BITS'(warning_level_r);
      REG_BATTERY_SUPPLY: cfg_prdata = CFG_DATA_BITS'(battery_supply_r);
      REG_START_ENABLED:  cfg_prdata = CFG_DATA_BITS'(start_enabled_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // compute stage advances whenever the result register is free or being drained
  assign fire     = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~fire;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  assign first           = ~primed_r;
  assign prev_sample_nxt = in_data_r.supply_code[SAMPLE_BITS-1:0];

  bmrg_iir u_iir (
    .sample      (prev_sample_nxt),
    .prev_sample (prev_sample_r),
    .level_prev  (filter_out_r),
    .coef        (coef_r),
    .first       (first),
    .level       (filter_out_nxt)
  );

  always_comb begin
    below_c_nxt = filter_out_nxt < {critical_level_r, {LEVEL_FRAC_BITS{1'b0}}};
    below_w_nxt = filter_out_nxt < {warning_level_r, {LEVEL_FRAC_BITS{1'b0}}};
    button_enable_nxt = (first ? start_enabled_r : button_enable_r) ^ in_data_r.button_press;
    // on mains supply a critical level leaves voltage-ok alone
    if (below_c_nxt) begin
      voltage_ok_nxt = battery_supply_r ? 1'b0 : voltage_ok_r;
    end else begin
      voltage_ok_nxt = 1'b1;
    end
    drive_nxt = button_enable_nxt & voltage_ok_nxt;
    out_data_nxt.filtered_level = filter_out_nxt;
    out_data_nxt.below_warning  = below_w_nxt;
    out_data_nxt.below_critical = below_c_nxt;
    out_data_nxt.drive_enable   = drive_nxt;
    out_data_nxt.enable_changed = first | (drive_nxt != last_reported_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r   <= '0;
      filter_out_r    <= '0;
      button_enable_r <= START_ENABLED_RST;
      voltage_ok_r    <= 1'b0;
      last_reported_r <= 1'b0;
      primed_r        <= 1'b0;
    end else if (fire) begin
      prev_sample_r   <= prev_sample_nxt;
      filter_out_r    <= filter_out_nxt;
      button_enable_r <= button_enable_nxt;
      voltage_ok_r    <= voltage_ok_nxt;
      last_reported_r <= drive_nxt;
      primed_r        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && in_valid_r))
    else $error("input stalled while result register can drain");

  a_first_forces_change: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !primed_r) |-> out_data_nxt.enable_changed)
    else $error("first request did not flag an enable change");

  a_primed_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (primed_r && out_valid_r))
    else $error("request completed without priming filter or raising result");

  a_critical_implies_warning: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (critical_level_r <= warning_level_r) && below_c_nxt) |-> below_w_nxt)
    else $error("below critical but not below warning");

  a_drive_needs_voltage: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (!last_reported_r || voltage_ok_r))
    else $error("drive enabled without voltage ok");

endmodule

>>> test/battery_monitor_regulation_gate_core_tb.sv
`timescale 1ns / 1ps

module battery_monitor_regulation_gate_core_tb;
  import bmrg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS = 125;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  bmrg_in_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  bmrg_out_t                out_data;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  battery_monitor_regulation_gate_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register mirror
  logic [COEF_BITS-1:0]   coef_b0    = COEF_B0_RST;
  logic [COEF_BITS-1:0]   coef_b1    = COEF_B1_RST;
  logic [COEF_BITS-1:0]   coef_a0    = COEF_A0_RST;
  logic [THRESH_BITS-1:0] crit_level = CRITICAL_LEVEL_RST;
  logic [THRESH_BITS-1:0] warn_level = WARNING_LEVEL_RST;
  logic                   on_battery = BATTERY_SUPPLY_RST;
  logic                   start_en   = START_ENABLED_RST;

  // monitor state
  logic [11:0] prev_code  = '0;
  logic [19:0] level_q    = '0;
  logic        button_en  = START_ENABLED_RST;
  logic        volt_ok    = 1'b0;
  logic        last_drive = 1'b0;
  logic        primed     = 1'b0;

  bmrg_out_t pending_readings[$];
  bmrg_out_t want;
  int        error_count = 0;
  int        cycle_count = 0;
  bit        burst_mode = 0;
  bit        hold_request = 0;
  int        hold_cycles = 0;
  int        stall_len = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int rand_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bmrg_out_t predict_reading(bmrg_in_t req);
    bmrg_out_t   r;
    longint      acc;
    logic [19:0] level;
    logic        first;
    logic        drive;
    first = !primed;
    if (first) begin
      button_en = start_en;
      level = {req.supply_code, 8'b0};
    end else begin
      acc = longint'($signed(coef_b0)) * longint'({req.supply_code, 8'b0})
          + longint'($signed(coef_b1)) * longint'({prev_code, 8'b0})
          - longint'($signed(coef_a0)) * longint'(level_q);
      acc += 64'sd1 <<< (COEF_FRAC_BITS - 1);
      if (acc <= 0)
        level = '0;
      else if ((acc >>> COEF_FRAC_BITS) > longint'(20'hFFFFF))
        level = '1;
      else
        level = acc[COEF_FRAC_BITS +: 20];
    end
    prev_code = req.supply_code;
    level_q = level;
    if (req.button_press) button_en = !button_en;
    r.filtered_level = level;
    r.below_critical = level < {crit_level, 8'b0};
    r.below_warning  = level < {warn_level, 8'b0};
    // mains supply: a critical level leaves voltage-ok alone
    if (r.below_critical) begin
      if (on_battery) volt_ok = 1'b0;
    end else begin
      volt_ok = 1'b1;
    end
    drive = button_en & volt_ok;
    r.drive_enable = drive;
    r.enable_changed = first || (drive != last_drive);
    last_drive = drive;
    primed = 1'b1;
    return r;
  endfunction

  task automatic send_request(logic [11:0] code, logic press);
    bmrg_in_t req;
    int       gap;
    req.supply_code = code;
    req.button_press = press;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_reading(req));
    gap = burst_mode ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bmrg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_COEF_B0:        coef_b0 = val[COEF_BITS-1:0];
      REG_COEF_B1:        coef_b1 = val[COEF_BITS-1:0];
      REG_COEF_A0:        coef_a0 = val[COEF_BITS-1:0];
      REG_CRITICAL_LEVEL: crit_level = val[THRESH_BITS-1:0];
      REG_WARNING_LEVEL:  warn_level = val[THRESH_BITS-1:0];
      REG_BATTERY_SUPPLY: on_battery = val[0];
      REG_START_ENABLED:  start_en = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] b0, logic [15:0] b1, logic [15:0] a0,
                            logic [11:0] crit, logic [11:0] warn, logic batt, logic start);
    write_reg(REG_COEF_B0, 32'(b0));
    write_reg(REG_COEF_B1, 32'(b1));
    write_reg(REG_COEF_A0, 32'(a0));
    write_reg(REG_CRITICAL_LEVEL, 32'(crit));
    write_reg(REG_WARNING_LEVEL, 32'(warn));
    write_reg(REG_BATTERY_SUPPLY, 32'(batt));
    write_reg(REG_START_ENABLED, 32'(start));
  endtask

  // start_enabled written after reset takes effect on the first tick,
  // and a press on that tick toggles it
  task automatic test_first_tick();
    write_reg(REG_START_ENABLED, 32'd0);
    send_request(12'd4095, 1'b1);
    send_request(12'd0, 1'b0);
    send_request(12'd0, 1'b1);
    send_request(12'd0, 1'b0);
    send_request(12'd4095, 1'b0);
  endtask

  // pass-through filter, warning threshold under the critical one
  task automatic test_thresholds();
    wait_idle();
    set_config(16'd16384, 16'd0, 16'd0, 12'd2000, 12'd1000, 1'b1, 1'b1);
    send_request(12'd1999, 1'b0);
    send_request(12'd2000, 1'b0);
    send_request(12'd999, 1'b0);
    send_request(12'd1000, 1'b1);
    send_request(12'd2500, 1'b1);
    send_request(12'd0, 1'b0);
    send_request(12'd4095, 1'b0);
  endtask

  task automatic test_mains_supply();
    wait_idle();
    write_reg(REG_BATTERY_SUPPLY, 32'd0);
    send_request(12'd3000, 1'b0);
    send_request(12'd100, 1'b0);
    send_request(12'd100, 1'b1);
    send_request(12'd2500, 1'b1);
  endtask

  task automatic test_coef_extremes();
    wait_idle();
    set_config(16'h7FFF, 16'h7FFF, 16'h8000, 12'd0, 12'd4095, 1'b1, 1'b0);
    send_request(12'd4095, 1'b0);
    send_request(12'd4095, 1'b1);
    wait_idle();
    set_config(16'h8000, 16'h8000, 16'h7FFF, 12'd4095, 12'd0, 1'b1, 1'b1);
    send_request(12'd4095, 1'b0);
    send_request(12'd0, 1'b0);
    send_request(12'd2048, 1'b1);
  endtask

  // receiver holds off long enough for the block to back up into in_stall
  task automatic test_backpressure();
    wait_idle();
    set_config(16'd2048, 16'd2048, 16'hE000, 12'd1500, 12'd2500, 1'b1, 1'b1);
    hold_cycles = 150;
    hold_request = 1;
    while (hold_request) @(posedge clk);
    burst_mode = 1;
    repeat (40) send_request(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    burst_mode = 0;
  endtask

  function automatic logic [15:0] pick_coef_extreme();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [11:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] pick_code();
    int base;
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2, 3, 4: begin
        base = $urandom_range(0, 1) ? int'(crit_level) : int'(warn_level);
        base += $urandom_range(0, 64) - 32;
        if (base < 0) base = 0;
        if (base > 4095) base = 4095;
        return 12'(base);
      end
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_random();
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] a0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: begin
          // DC gain of one half, random split between the two taps
          b0 = 16'($urandom_range(0, 4096));
          b1 = 16'd4096 - b0;
          a0 = 16'hE000;
        end
        1: begin
          b0 = 16'($urandom);
          b1 = 16'($urandom);
          a0 = 16'($urandom);
        end
        2: begin
          b0 = pick_coef_extreme();
          b1 = pick_coef_extreme();
          a0 = pick_coef_extreme();
        end
        default: begin
          b0 = 16'd16384;
          b1 = 16'd0;
          a0 = 16'd0;
        end
      endcase
      set_config(b0, b1, a0, pick_level(), pick_level(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      burst_mode = (p % 4 == 1);
      repeat (PHASE_ITEMS) send_request(pick_code(), $urandom_range(0, 7) == 0);
      burst_mode = 0;
    end
  endtask

  // result side stall pattern
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6)) @(posedge clk);
        stall_len = rand_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_error($sformatf("result with none expected, level %0d",
                               out_data.filtered_level));
      end else begin
        want = pending_readings.pop_front();
        if (out_data.filtered_level !== want.filtered_level)
          report_error($sformatf("filtered_level got %0d expected %0d",
                                 out_data.filtered_level, want.filtered_level));
        if (out_data.below_warning !== want.below_warning)
          report_error($sformatf("below_warning got %b expected %b",
                                 out_data.below_warning, want.below_warning));
        if (out_data.below_critical !== want.below_critical)
          report_error($sformatf("below_critical got %b expected %b",
                                 out_data.below_critical, want.below_critical));
        if (out_data.drive_enable !== want.drive_enable)
          report_error($sformatf("drive_enable got %b expected %b",
                                 out_data.drive_enable, want.drive_enable));
        if (out_data.enable_changed !== want.enable_changed)
          report_error($sformatf("enable_changed got %b expected %b",
                                 out_data.enable_changed, want.enable_changed));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_tick();
    test_thresholds();
    test_mains_supply();
    test_coef_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
